### src/ptp_pkg.sv
// Shared types, widths and constants of the pan-tilt PID speed command block.
package ptp_pkg;

    // Field and register widths
    localparam int OP_W       = 2;
    localparam int GAIN_W     = 32;
    localparam int CENTER_W   = 10;
    localparam int TOL_W      = 8;
    localparam int STEP_W     = 13;
    localparam int PAN_W      = 14;
    localparam int TILT_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Parameter defaults
    localparam int PIXEL_BITS_DEF = 10;
    localparam int SUM_BITS_DEF   = 32;

    // Shared multiplier: 32-bit magnitude times 48-bit magnitude, 24 bits per pass
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 48;
    localparam int MUL_CHUNK_W = 24;
    localparam int MUL_NCH     = MUL_B_W / MUL_CHUNK_W;
    localparam int MUL_CNT_W   = $clog2(MUL_NCH);
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // PID term and speed arithmetic
    localparam int TERM_W    = 47;
    localparam int ACC_W     = 49;
    localparam int U_W       = 64;
    localparam int FRAC_BITS = 30;
    localparam logic [MUL_P_W-1:0] TERM_LIM = MUL_P_W'(1) << (TERM_W - 1);

    // Q1.14 axis scale factors and speed limits
    localparam int SCALE_W    = 15;
    localparam int PAN_SCALE  = 9077;
    localparam int TILT_SCALE = 18186;
    localparam int SPEED_MIN  = 60;
    localparam int PAN_MAX    = 5000;
    localparam int TILT_MAX   = 2500;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_REPORT = 2'd1,
        OP_TOGGLE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_CENTER_X   = 3'd3,
        CFG_CENTER_Y   = 3'd4,
        CFG_PIXEL_TOL  = 3'd5,
        CFG_PAN_STEP   = 3'd6,
        CFG_TILT_STEP  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integral;
        logic signed [GAIN_W-1:0] gain_deriv;
        logic [CENTER_W-1:0]      center_x;
        logic [CENTER_W-1:0]      center_y;
        logic [TOL_W-1:0]         pixel_tolerance;
        logic [STEP_W-1:0]        pan_step_limit;
        logic [STEP_W-1:0]        tilt_step_limit;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        gain_prop:       '0,
        gain_integral:   '0,
        gain_deriv:      '0,
        center_x:        CENTER_W'(320),
        center_y:        CENTER_W'(180),
        pixel_tolerance: TOL_W'(3),
        pan_step_limit:  STEP_W'(400),
        tilt_step_limit: STEP_W'(800)
    };

endpackage

### src/ptp_in_if.sv
// Input channel: valid/ready handshake carrying op and target pixel.
interface ptp_in_if
    import ptp_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;

    modport source (output valid, output op, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input op, input pixel_x, input pixel_y, output ready);
endinterface

### src/ptp_out_if.sv
// Output channel: valid/ready handshake carrying the pan and tilt speed command.
interface ptp_out_if
    import ptp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [PAN_W-1:0]  pan_speed;
    logic signed [TILT_W-1:0] tilt_speed;
    logic                     tracking_active;

    modport source (output valid, output pan_speed, output tilt_speed,
                    output tracking_active, input ready);
    modport sink   (input valid, input pan_speed, input tilt_speed,
                    input tracking_active, output ready);
endinterface

### src/ptp_cfg.sv
// Configuration register file with reset values and index decode.
module ptp_cfg
    import ptp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_PROP:  r_cfg.gain_prop       <= i_cfg_data;
                CFG_GAIN_INTEG: r_cfg.gain_integral   <= i_cfg_data;
                CFG_GAIN_DERIV: r_cfg.gain_deriv      <= i_cfg_data;
                CFG_CENTER_X:   r_cfg.center_x        <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:   r_cfg.center_y        <= i_cfg_data[CENTER_W-1:0];
                CFG_PIXEL_TOL:  r_cfg.pixel_tolerance <= i_cfg_data[TOL_W-1:0];
                CFG_PAN_STEP:   r_cfg.pan_step_limit  <= i_cfg_data[STEP_W-1:0];
                CFG_TILT_STEP:  r_cfg.tilt_step_limit <= i_cfg_data[STEP_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/ptp_mul.sv
// Iterative unsigned multiplier: one 32x24 partial product per cycle, MSB chunk first.
module ptp_mul
    import ptp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_prod
);

    logic                               r_busy;
    logic                               r_done;
    logic [MUL_CNT_W-1:0]               r_cnt;
    logic [MUL_A_W-1:0]                 r_a;
    logic [MUL_B_W-1:0]                 r_b;
    logic [MUL_P_W-1:0]                 r_acc;
    logic [MUL_A_W+MUL_CHUNK_W-1:0]     pp;

    assign pp = r_a * r_b[r_cnt*MUL_CHUNK_W +: MUL_CHUNK_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse done after the last chunk
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= MUL_CNT_W'(MUL_NCH - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // shift in the next lower chunk
                r_acc <= (r_acc << MUL_CHUNK_W) + MUL_P_W'(pp);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### src/pan_tilt_pid_speed_command.sv
// Top level: two-axis PID speed command sequencer around one shared multiplier.
//
//  Channel  Dir  Beat contents                                  Flow control
//  i_in     in   op, pixel_x, pixel_y                           valid / ready
//  o_out    out  pan_speed, tilt_speed, tracking_active         valid / ready
//  cfg      in   i_cfg_index, i_cfg_data                        i_cfg_wr_en, never stalls
//
//  Report, toggle and dropped samples are each handled in S_IDLE. A handled sample with control
//  on runs per axis four multiplies through ptp_mul (P alone and the scale on the first step
//  after a toggle), then the states S_RL, S_LIM, S_FIX and S_RND for rate limiting, flooring,
//  saturation and rounding. With control off a sample goes straight to S_OUT with zero
//  speeds.
//  Reset is synchronous, active low; it clears control state and loads register defaults.
//  i_in is held off while a sample is in flight; the finished beat waits in the output
//  register, and a following sample stalls only if that beat is still not taken.
module pan_tilt_pid_speed_command
    import ptp_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int SUM_BITS   = SUM_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ptp_in_if.sink                i_in,
    ptp_out_if.source             o_out
);

    // error width covers center minus pixel for either operand width
    localparam int E_W     = ((PIXEL_BITS > CENTER_W) ? PIXEL_BITS : CENTER_W) + 1;
    localparam int DE_W    = E_W + 1;
    localparam int UMAX_W  = $clog2(PAN_MAX + 1);

    localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(1) <<< (TERM_W - 1);
    localparam logic signed [U_W-1:0]   MIN_U   = U_W'(SPEED_MIN) <<< FRAC_BITS;
    localparam logic [U_W-1:0]          HALF_U  = U_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_GO,
        S_P_WAIT,
        S_I_GO,
        S_I_WAIT,
        S_D_GO,
        S_D_WAIT,
        S_S_GO,
        S_S_WAIT,
        S_RL,
        S_LIM,
        S_FIX,
        S_RND,
        S_OUT
    } t_state;

    t_cfg cfg;

    t_state                     r_state;
    logic signed [E_W-1:0]      r_err_x, r_err_y;
    logic signed [E_W-1:0]      r_prev_x, r_prev_y;
    logic signed [SUM_BITS-1:0] r_sum_x, r_sum_y;
    logic signed [PAN_W-1:0]    r_last_pan;
    logic signed [TILT_W-1:0]   r_last_tilt;
    logic                       r_far_x, r_far_y;
    logic                       r_first, r_ctrl, r_fresh, r_axis;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [U_W-1:0]      r_u;
    logic                       r_hi, r_lo, r_neg;
    logic signed [PAN_W-1:0]    r_res_pan;
    logic signed [TILT_W-1:0]   r_res_tilt;
    logic                       r_out_valid;
    logic signed [PAN_W-1:0]    r_out_pan;
    logic signed [TILT_W-1:0]   r_out_tilt;
    logic                       r_out_trk;

    // sample errors at accept
    logic signed [E_W-1:0] in_ex, in_ey;
    logic [E_W-1:0]        in_ax, in_ay;
    logic                  in_far_x, in_far_y;

    // per-axis selection
    logic signed [E_W-1:0]      s_err, s_prev;
    logic signed [SUM_BITS-1:0] s_sum;
    logic signed [PAN_W-1:0]    s_last;
    logic [STEP_W-1:0]          s_step;
    logic [UMAX_W-1:0]          s_umax;
    logic [SCALE_W-1:0]         s_scale;
    logic                       s_far;

    // shared multiplier
    logic               mul_start, mul_done, mul_neg;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;

    logic signed [DE_W-1:0]    d_err;
    logic signed [ACC_W-1:0]   acc_clamped;
    logic [TERM_W-1:0]         term_mag;
    logic signed [ACC_W-1:0]   term;
    logic signed [U_W-1:0]     u_scaled;
    logic signed [U_W-1:0]     old_u, lim_u, diff_u, umax_u, fix_u;
    logic                      in_band, pos;
    logic [U_W-1:0]            u_mag, u_rnd;
    logic signed [PAN_W-1:0]   rnd_val, res_val;
    logic signed [SUM_BITS:0]  sum_wide;
    logic signed [SUM_BITS-1:0] sum_new;

    ptp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ptp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // error = center - pixel, and the dead-zone test on its magnitude
    always_comb begin
        in_ex    = $signed(E_W'(cfg.center_x)) - $signed(E_W'(i_in.pixel_x));
        in_ey    = $signed(E_W'(cfg.center_y)) - $signed(E_W'(i_in.pixel_y));
        in_ax    = $unsigned(in_ex[E_W-1] ? -in_ex : in_ex);
        in_ay    = $unsigned(in_ey[E_W-1] ? -in_ey : in_ey);
        in_far_x = in_ax > E_W'(cfg.pixel_tolerance);
        in_far_y = in_ay > E_W'(cfg.pixel_tolerance);
    end

    always_comb begin
        s_err   = r_axis ? r_err_y  : r_err_x;
        s_prev  = r_axis ? r_prev_y : r_prev_x;
        s_sum   = r_axis ? r_sum_y  : r_sum_x;
        s_last  = r_axis ? PAN_W'(r_last_tilt) : r_last_pan;
        s_step  = r_axis ? cfg.tilt_step_limit : cfg.pan_step_limit;
        s_umax  = r_axis ? UMAX_W'(TILT_MAX) : UMAX_W'(PAN_MAX);
        s_scale = r_axis ? SCALE_W'(TILT_SCALE) : SCALE_W'(PAN_SCALE);
        s_far   = r_axis ? r_far_y : r_far_x;
    end

    // operand select: magnitudes into the unsigned multiplier, sign kept aside
    always_comb begin
        d_err = DE_W'(s_err) - DE_W'(s_prev);
        if (r_acc > ACC_LIM) begin
            acc_clamped = ACC_LIM;
        end else if (r_acc < -ACC_LIM) begin
            acc_clamped = -ACC_LIM;
        end else begin
            acc_clamped = r_acc;
        end
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        unique case (r_state)
            S_P_GO: begin
                mul_start = 1'b1;
                mul_a     = $unsigned(cfg.gain_prop[GAIN_W-1] ? -cfg.gain_prop
                                                              : cfg.gain_prop);
                mul_b     = MUL_B_W'($unsigned(s_err[E_W-1] ? -s_err : s_err));
                mul_neg   = cfg.gain_prop[GAIN_W-1] ^ s_err[E_W-1];
            end
            S_I_GO: begin
                mul_start = 1'b1;
                mul_a     = $unsigned(cfg.gain_integral[GAIN_W-1] ? -cfg.gain_integral
                                                                  : cfg.gain_integral);
                mul_b     = MUL_B_W'($unsigned(s_sum[SUM_BITS-1] ? -s_sum : s_sum));
                mul_neg   = cfg.gain_integral[GAIN_W-1] ^ s_sum[SUM_BITS-1];
            end
            S_D_GO: begin
                mul_start = 1'b1;
                mul_a     = $unsigned(cfg.gain_deriv[GAIN_W-1] ? -cfg.gain_deriv
                                                               : cfg.gain_deriv);
                mul_b     = MUL_B_W'($unsigned(d_err[DE_W-1] ? -d_err : d_err));
                mul_neg   = cfg.gain_deriv[GAIN_W-1] ^ d_err[DE_W-1];
            end
            S_S_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(s_scale);
                mul_b     = MUL_B_W'($unsigned(acc_clamped[ACC_W-1] ? -acc_clamped
                                                                    : acc_clamped));
                mul_neg   = acc_clamped[ACC_W-1];
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // saturate each PID product at 2^46 and restore its sign
    always_comb begin
        term_mag = (mul_prod > TERM_LIM) ? TERM_LIM[TERM_W-1:0] : mul_prod[TERM_W-1:0];
        term     = r_neg ? -$signed(ACC_W'(term_mag)) : $signed(ACC_W'(term_mag));
        u_scaled = r_neg ? -$signed(U_W'(mul_prod)) : $signed(U_W'(mul_prod));
    end

    // rate limit, floor, saturate, round
    always_comb begin
        old_u   = U_W'(s_last) <<< FRAC_BITS;
        lim_u   = $signed(U_W'(s_step)) <<< FRAC_BITS;
        umax_u  = $signed(U_W'(s_umax)) <<< FRAC_BITS;
        diff_u  = r_u - old_u;
        in_band = (r_u < MIN_U) && (r_u > -MIN_U);
        // a rate-limited speed takes the floor sign from the last command
        pos    = (r_hi || r_lo) ? !s_last[PAN_W-1] : !r_u[U_W-1];
        if (in_band) begin
            fix_u = s_far ? (pos ? MIN_U : -MIN_U) : '0;
        end else if (r_u > umax_u) begin
            fix_u = umax_u;
        end else if (r_u < -umax_u) begin
            fix_u = -umax_u;
        end else begin
            fix_u = r_u;
        end
        u_mag   = $unsigned(r_u[U_W-1] ? -r_u : r_u);
        u_rnd   = (u_mag + HALF_U) >> FRAC_BITS;
        rnd_val = $signed(PAN_W'(u_rnd));
        res_val = r_u[U_W-1] ? -rnd_val : rnd_val;
    end

    // error sum saturates at the sum width
    always_comb begin
        sum_wide = (SUM_BITS+1)'(s_sum) + (SUM_BITS+1)'(s_err);
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
            sum_new = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_new = sum_wide[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_last_pan  <= '0;
            r_last_tilt <= '0;
            r_first     <= 1'b1;
            r_ctrl      <= 1'b0;
            r_fresh     <= 1'b0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken beat unless S_OUT reloads the register this cycle
            if (r_out_valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        unique case (i_in.op)
                            OP_REPORT: begin
                                r_fresh <= 1'b1;
                            end
                            OP_TOGGLE: begin
                                r_ctrl   <= !r_ctrl;
                                r_prev_x <= '0;
                                r_prev_y <= '0;
                                r_sum_x  <= '0;
                                r_sum_y  <= '0;
                                r_first  <= 1'b1;
                                r_fresh  <= 1'b0;
                            end
                            OP_SAMPLE: begin
                                // drop a sample that has no fresh position report
                                if (r_fresh) begin
                                    r_fresh <= 1'b0;
                                    r_err_x <= in_ex;
                                    r_err_y <= in_ey;
                                    r_far_x <= in_far_x;
                                    r_far_y <= in_far_y;
                                    if (r_ctrl) begin
                                        r_axis  <= 1'b0;
                                        r_state <= S_P_GO;
                                    end else begin
                                        r_res_pan  <= '0;
                                        r_res_tilt <= '0;
                                        r_prev_x   <= in_ex;
                                        r_prev_y   <= in_ey;
                                        r_state    <= S_OUT;
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_P_GO: begin
                    r_neg   <= mul_neg;
                    r_state <= S_P_WAIT;
                end
                S_P_WAIT: begin
                    if (mul_done) begin
                        r_acc   <= term;
                        // first step after a toggle runs on P alone
                        r_state <= r_first ? S_S_GO : S_I_GO;
                    end
                end
                S_I_GO: begin
                    r_neg   <= mul_neg;
                    r_state <= S_I_WAIT;
                end
                S_I_WAIT: begin
                    if (mul_done) begin
                        r_acc   <= r_acc + term;
                        r_state <= S_D_GO;
                    end
                end
                S_D_GO: begin
                    r_neg   <= mul_neg;
                    r_state <= S_D_WAIT;
                end
                S_D_WAIT: begin
                    if (mul_done) begin
                        r_acc   <= r_acc + term;
                        r_state <= S_S_GO;
                    end
                end
                S_S_GO: begin
                    r_neg   <= mul_neg;
                    r_state <= S_S_WAIT;
                end
                S_S_WAIT: begin
                    if (mul_done) begin
                        r_u     <= u_scaled;
                        r_state <= S_RL;
                    end
                end
                S_RL: begin
                    r_hi    <= diff_u > lim_u;
                    r_lo    <= diff_u < -lim_u;
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    if (r_hi) begin
                        r_u <= old_u + lim_u;
                    end else if (r_lo) begin
                        r_u <= old_u - lim_u;
                    end
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_u     <= fix_u;
                    r_state <= S_RND;
                end
                S_RND: begin
                    if (r_axis) begin
                        r_res_tilt  <= TILT_W'(res_val);
                        r_last_tilt <= TILT_W'(res_val);
                        r_sum_y     <= sum_new;
                        r_first     <= 1'b0;
                        r_prev_x    <= r_err_x;
                        r_prev_y    <= r_err_y;
                        r_state     <= S_OUT;
                    end else begin
                        r_res_pan  <= res_val;
                        r_last_pan <= res_val;
                        r_sum_x    <= sum_new;
                        r_axis     <= 1'b1;
                        r_state    <= S_P_GO;
                    end
                end
                S_OUT: begin
                    // hold until the previous beat has left the output register
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pan   <= r_res_pan;
                        r_out_tilt  <= r_res_tilt;
                        r_out_trk   <= r_ctrl;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.pan_speed       = r_out_pan;
    assign o_out.tilt_speed      = r_out_tilt;
    assign o_out.tracking_active = r_out_trk;

endmodule

### dv/pan_tilt_pid_speed_command_tb.sv
// Self-checking testbench for the pan-tilt PID speed command block.
`timescale 1ns / 1ps

module pan_tilt_pid_speed_command_tb;
    import ptp_pkg::*;

    // Sizes of the run
    localparam int PIX_W         = PIXEL_BITS_DEF;
    localparam int PIX_MAX       = (1 << PIX_W) - 1;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 1000000;

    // Op code that the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Fixed-point limits of the speed arithmetic
    localparam longint ONE_Q    = 64'sd1 <<< FRAC_BITS;
    localparam longint TERM_CAP = 64'sd1 <<< (TERM_W - 1);
    localparam longint SUM_HI   = (64'sd1 <<< (SUM_BITS_DEF - 1)) - 1;
    localparam longint SUM_LO   = -SUM_HI - 1;

    typedef struct packed {
        logic signed [PAN_W-1:0]  pan;
        logic signed [TILT_W-1:0] tilt;
        logic                     active;
    } t_speed_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ptp_in_if #(.PIXEL_BITS(PIX_W)) sample_ch ();
    ptp_out_if                      cmd_ch ();

    pan_tilt_pid_speed_command #(
        .PIXEL_BITS(PIX_W),
        .SUM_BITS  (SUM_BITS_DEF)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch),
        .o_out      (cmd_ch)
    );

    // Tracker shadow state: register copy plus the controller state as it evolves
    t_cfg   cfg_model      = CFG_RST;
    bit     tracking_on    = 1'b0;
    bit     p_only_next    = 1'b1;
    bit     report_pending = 1'b0;
    int     err_hold_x     = 0;
    int     err_hold_y     = 0;
    int     pan_cmd_q      = 0;
    int     tilt_cmd_q     = 0;
    longint integ_x        = 0;
    longint integ_y        = 0;

    t_speed_cmd cmd_expected[$];
    t_speed_cmd want_cmd;

    // Run bookkeeping
    int fail_count    = 0;
    int beats_sent    = 0;
    int cmds_checked  = 0;
    int toggles_seen  = 0;
    int settings_done = 0;
    int cycle_count   = 0;

    // Idling controls shared by the sender and the receiver
    bit gaps_en    = 1'b1;
    bit stall_en   = 1'b1;
    int burst_left = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int run_left   = 0;
    bit run_ready  = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Signed product clamped to the term limit, as the block does with each PID product.
    function automatic longint clamp_product(input longint a, input longint b);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        if (ma == 0 || mb == 0) return 0;
        if (mb > longint'(TERM_CAP) / ma) m = TERM_CAP;
        else m = ma * mb;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // One axis: PID sum, axis scale, rate limit, minimum speed, saturation, rounding.
    function automatic int axis_command(input int err, input int err_old,
                                        inout longint integ, input longint scale,
                                        input int cmd_old, input longint step,
                                        input longint cap, input bit off_center);
        longint acc, u, old_q, lim_q, floor_q, mag;
        acc = clamp_product($signed(cfg_model.gain_prop), err);
        if (!p_only_next) begin
            acc += clamp_product($signed(cfg_model.gain_integral), integ);
            acc += clamp_product($signed(cfg_model.gain_deriv), longint'(err) - err_old);
            if (acc > TERM_CAP) acc = TERM_CAP;
            else if (acc < -TERM_CAP) acc = -TERM_CAP;
        end
        integ += err;
        if (integ > SUM_HI) integ = SUM_HI;
        else if (integ < SUM_LO) integ = SUM_LO;

        u       = acc * scale;
        old_q   = longint'(cmd_old) * ONE_Q;
        lim_q   = step * ONE_Q;
        floor_q = SPEED_MIN * ONE_Q;

        // Rate limit: a clipped step that lands in the dead band follows the old sign
        if (u - old_q > lim_q || old_q - u > lim_q) begin
            u = (u > old_q) ? old_q + lim_q : old_q - lim_q;
            if (u < floor_q && u > -floor_q)
                u = !off_center ? 0 : ((cmd_old >= 0) ? floor_q : -floor_q);
        end
        if (u < floor_q && u > -floor_q)
            u = !off_center ? 0 : ((u >= 0) ? floor_q : -floor_q);
        else if (u > cap * ONE_Q)
            u = cap * ONE_Q;
        else if (u < -cap * ONE_Q)
            u = -cap * ONE_Q;

        // Round half away from zero
        mag = (u < 0) ? -u : u;
        mag = (mag + ONE_Q / 2) / ONE_Q;
        return int'((u < 0) ? -mag : mag);
    endfunction

    // Advance the shadow state by one accepted beat and queue the command it causes.
    task automatic predict_speed_cmd(input logic [OP_W-1:0] op,
                                     input logic [PIX_W-1:0] px,
                                     input logic [PIX_W-1:0] py);
        int ex, ey, pan, tilt;
        bit far_x, far_y;
        t_speed_cmd cmd;
        pan  = 0;
        tilt = 0;
        case (op)
            OP_REPORT: report_pending = 1'b1;
            OP_TOGGLE: begin
                tracking_on    = !tracking_on;
                err_hold_x     = 0;
                err_hold_y     = 0;
                integ_x        = 0;
                integ_y        = 0;
                p_only_next    = 1'b1;
                report_pending = 1'b0;
                toggles_seen++;
            end
            OP_SAMPLE: begin
                if (report_pending) begin
                    report_pending = 1'b0;
                    ex = int'(cfg_model.center_x) - int'(px);
                    ey = int'(cfg_model.center_y) - int'(py);
                    if (tracking_on) begin
                        far_x = ((ex < 0) ? -ex : ex) > int'(cfg_model.pixel_tolerance);
                        far_y = ((ey < 0) ? -ey : ey) > int'(cfg_model.pixel_tolerance);
                        pan  = axis_command(ex, err_hold_x, integ_x, PAN_SCALE, pan_cmd_q,
                                            cfg_model.pan_step_limit, PAN_MAX, far_x);
                        tilt = axis_command(ey, err_hold_y, integ_y, TILT_SCALE, tilt_cmd_q,
                                            cfg_model.tilt_step_limit, TILT_MAX, far_y);
                        p_only_next = 1'b0;
                        pan_cmd_q   = pan;
                        tilt_cmd_q  = tilt;
                    end
                    err_hold_x = ex;
                    err_hold_y = ey;
                    cmd.pan    = PAN_W'(pan);
                    cmd.tilt   = TILT_W'(tilt);
                    cmd.active = tracking_on;
                    cmd_expected = {cmd_expected, cmd};
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [PIX_W-1:0] rand_pixel();
        return PIX_W'($urandom_range(0, PIX_MAX));
    endfunction

    // Pixel near the center about a third of the time, so the dead band is hit often.
    function automatic logic [PIX_W-1:0] pick_pixel(input logic [CENTER_W-1:0] ctr,
                                                   input logic [TOL_W-1:0] tol);
        int v;
        if ($urandom_range(0, 2) != 0) return rand_pixel();
        v = int'(ctr) - int'(tol) - 4 + int'($urandom_range(0, 2 * int'(tol) + 8));
        if (v < 0) v = 0;
        else if (v > PIX_MAX) v = PIX_MAX;
        return PIX_W'(v);
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain(input int span);
        return GAIN_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Register set for one phase: the first three are corner settings, the rest random.
    function automatic t_cfg phase_config(input int ph);
        t_cfg c;
        case (ph)
            0: begin
                c.gain_prop       = 32'h7FFF_FFFF;
                c.gain_integral   = 32'h7FFF_FFFF;
                c.gain_deriv      = 32'h7FFF_FFFF;
                c.center_x        = CENTER_W'(PIX_MAX);
                c.center_y        = CENTER_W'(PIX_MAX);
                c.pixel_tolerance = '1;
                c.pan_step_limit  = '1;
                c.tilt_step_limit = '1;
            end
            1: begin
                c.gain_prop       = 32'h8000_0000;
                c.gain_integral   = 32'h8000_0000;
                c.gain_deriv      = 32'h8000_0000;
                c.center_x        = '0;
                c.center_y        = '0;
                c.pixel_tolerance = '0;
                c.pan_step_limit  = '0;
                c.tilt_step_limit = '0;
            end
            2: begin
                c.gain_prop       = 32'hFFFF_FFFF;
                c.gain_integral   = '0;
                c.gain_deriv      = 32'h0000_0001;
                c.center_x        = CENTER_W'(PIX_MAX);
                c.center_y        = '0;
                c.pixel_tolerance = TOL_W'(1);
                c.pan_step_limit  = STEP_W'(1);
                c.tilt_step_limit = '1;
            end
            default: begin
                c.gain_prop       = rand_gain(6 << 16);
                c.gain_integral   = rand_gain(1 << 14);
                c.gain_deriv      = rand_gain(1 << 16);
                c.center_x        = CENTER_W'($urandom_range(0, PIX_MAX));
                c.center_y        = CENTER_W'($urandom_range(0, PIX_MAX));
                c.pixel_tolerance = TOL_W'(($urandom_range(0, 4) == 0) ?
                                           $urandom_range(0, 255) : $urandom_range(0, 12));
                c.pan_step_limit  = STEP_W'(($urandom_range(0, 3) == 0) ?
                                           $urandom_range(0, 8191) : $urandom_range(0, 800));
                c.tilt_step_limit = STEP_W'(($urandom_range(0, 3) == 0) ?
                                           $urandom_range(0, 8191) : $urandom_range(0, 800));
            end
        endcase
        return c;
    endfunction

    // Offer one beat at the falling edge, hold it until accepted, then predict.
    // Bursts of random length are separated by random gaps when gaps are enabled.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] px,
                             input logic [PIX_W-1:0] py);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_en ? $urandom_range(0, 10) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                sample_ch.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        sample_ch.valid   <= 1'b1;
        sample_ch.op      <= op;
        sample_ch.pixel_x <= px;
        sample_ch.pixel_y <= py;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        beats_sent++;
        predict_speed_cmd(op, px, py);
    endtask

    // Well-formed frame: a position report followed by the target pixel.
    task automatic send_pair(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        send_beat(OP_REPORT, rand_pixel(), rand_pixel());
        send_beat(OP_SAMPLE, px, py);
    endtask

    // Drop valid and hold off until every queued command has come back.
    task automatic drain_results();
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // Write all registers once the block is idle; a no-result beat may still be in
    // flight after the last command, so let the block settle first.
    task automatic apply_config(input t_cfg c);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_GAIN_PROP,  c.gain_prop);
        write_reg(CFG_GAIN_INTEG, c.gain_integral);
        write_reg(CFG_GAIN_DERIV, c.gain_deriv);
        write_reg(CFG_CENTER_X,   CFG_DATA_W'(c.center_x));
        write_reg(CFG_CENTER_Y,   CFG_DATA_W'(c.center_y));
        write_reg(CFG_PIXEL_TOL,  CFG_DATA_W'(c.pixel_tolerance));
        write_reg(CFG_PAN_STEP,   CFG_DATA_W'(c.pan_step_limit));
        write_reg(CFG_TILT_STEP,  CFG_DATA_W'(c.tilt_step_limit));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_model = c;
        settings_done++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers (zero gains): stray sample, unused op, control off, dead band
    // edge, minimum speed at the pixel extremes.
    task automatic test_reset_behavior();
        send_beat(OP_SAMPLE, PIX_W'(5), PIX_W'(5));
        send_beat(OP_UNUSED, PIX_W'(PIX_MAX), PIX_W'(PIX_MAX));
        send_pair(PIX_W'(100), PIX_W'(100));
        send_beat(OP_TOGGLE, '0, '0);
        send_pair(PIX_W'(CFG_RST.center_x + 3), PIX_W'(CFG_RST.center_y - 3));
        send_pair(PIX_W'(CFG_RST.center_x - 4), PIX_W'(CFG_RST.center_y + 4));
        send_pair('0, PIX_W'(PIX_MAX));
        send_pair(PIX_W'(PIX_MAX), '0);
    endtask

    // Full-scale gains and limits: saturation on the first step, clamped PID sum,
    // double report, and a toggle that discards a pending report.
    task automatic test_speed_limits();
        t_cfg c;
        c = phase_config(0);
        c.gain_integral = 32'h8000_0000;
        c.center_y      = '0;
        apply_config(c);
        send_beat(OP_TOGGLE, '0, '0);
        send_beat(OP_TOGGLE, '1, '1);
        send_pair('0, PIX_W'(PIX_MAX));
        send_pair(PIX_W'(PIX_MAX), '0);
        send_beat(OP_REPORT, rand_pixel(), rand_pixel());
        send_pair(PIX_W'(768), PIX_W'(300));
        send_beat(OP_REPORT, rand_pixel(), rand_pixel());
        send_beat(OP_TOGGLE, rand_pixel(), rand_pixel());
        send_beat(OP_SAMPLE, PIX_W'(10), PIX_W'(10));
        send_pair(PIX_W'(512), PIX_W'(512));
    endtask

    // Several register settings, each followed by mostly well-formed frames with
    // random content, mixed with stray samples, extra reports, toggles and noise.
    task automatic test_random_tracking();
        int ph, taken, pick;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            // Phase 2 runs with no idling on either side
            gaps_en  = (ph != 2);
            stall_en = (ph != 2);
            apply_config(phase_config(ph));
            if (!tracking_on) send_beat(OP_TOGGLE, rand_pixel(), rand_pixel());
            taken = 0;
            while (taken < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // Keep control on most of the time so the PID path stays busy
                    if (!tracking_on && $urandom_range(0, 3) != 0) begin
                        send_beat(OP_TOGGLE, rand_pixel(), rand_pixel());
                        taken++;
                    end
                    send_pair(pick_pixel(cfg_model.center_x, cfg_model.pixel_tolerance),
                              pick_pixel(cfg_model.center_y, cfg_model.pixel_tolerance));
                    taken += 2;
                end else if (pick < 77) begin
                    send_beat(OP_SAMPLE, rand_pixel(), rand_pixel());
                end else if (pick < 85) begin
                    send_beat(OP_REPORT, rand_pixel(), rand_pixel());
                    taken++;
                end else if (pick < 90) begin
                    send_beat(OP_TOGGLE, rand_pixel(), rand_pixel());
                    taken++;
                end else if (pick < 95) begin
                    send_beat(OP_UNUSED, rand_pixel(), rand_pixel());
                end else if (pick < 99) begin
                    // Broken frame: the toggle discards the report
                    send_beat(OP_REPORT, rand_pixel(), rand_pixel());
                    send_beat(OP_TOGGLE, rand_pixel(), rand_pixel());
                    send_beat(OP_SAMPLE, rand_pixel(), rand_pixel());
                    taken += 3;
                end else begin
                    // Pause the sender until every command is back
                    drain_results();
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while frames keep coming, so the output
    // register fills and the input stalls.
    task automatic test_output_backpressure();
        int n;
        gaps_en  = 1'b0;
        stall_en = 1'b1;
        apply_config(phase_config(RAND_PHASES));
        if (!tracking_on) send_beat(OP_TOGGLE, rand_pixel(), rand_pixel());
        hold_req = HOLD_CYCLES;
        for (n = 0; n < 20; n++) send_pair(rand_pixel(), rand_pixel());
        drain_results();
        gaps_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: long hold-off on request, always ready when stalls are off, otherwise
    // alternating ready and stall runs, with an occasional long run of no stalls.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            cmd_ch.ready <= 1'b0;
        end else if (!stall_en) begin
            cmd_ch.ready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                run_ready = !run_ready;
                run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
                if (run_ready && $urandom_range(0, 15) == 0) run_left = $urandom_range(40, 120);
            end
            run_left--;
            cmd_ch.ready <= run_ready;
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare every accepted command beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
            if (cmd_expected.size() == 0) begin
                $error("speed command with no sample pending: pan %0d tilt %0d active %0d",
                       cmd_ch.pan_speed, cmd_ch.tilt_speed, cmd_ch.tracking_active);
                fail_count++;
            end else begin
                want_cmd = cmd_expected.pop_front();
                if (cmd_ch.pan_speed !== want_cmd.pan) begin
                    $error("pan_speed mismatch: expected %0d, got %0d",
                           want_cmd.pan, cmd_ch.pan_speed);
                    fail_count++;
                end
                if (cmd_ch.tilt_speed !== want_cmd.tilt) begin
                    $error("tilt_speed mismatch: expected %0d, got %0d",
                           want_cmd.tilt, cmd_ch.tilt_speed);
                    fail_count++;
                end
                if (cmd_ch.tracking_active !== want_cmd.active) begin
                    $error("tracking_active mismatch: expected %0d, got %0d",
                           want_cmd.active, cmd_ch.tracking_active);
                    fail_count++;
                end
                cmds_checked++;
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timeout after %0d cycles, %0d commands outstanding",
               cycle_count, cmd_expected.size());
        $display("pan_tilt_pid_speed_command_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = CFG_GAIN_PROP;
        i_cfg_data        = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.op      = OP_SAMPLE;
        sample_ch.pixel_x = '0;
        sample_ch.pixel_y = '0;
        cmd_ch.ready      = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_behavior();
        test_speed_limits();
        test_random_tracking();
        test_output_backpressure();

        // Wait out anything still in flight; a stray beat would show up here
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (cmd_expected.size() != 0) begin
            $error("%0d predicted commands never arrived", cmd_expected.size());
            fail_count++;
        end

        $display("Run covered %0d input beats and %0d checked speed commands,",
                 beats_sent, cmds_checked);
        $display("over %0d register settings and %0d control toggles.",
                 settings_done, toggles_seen);
        if (fail_count == 0) begin
            $display("pan_tilt_pid_speed_command_tb: PASS");
        end else begin
            $display("pan_tilt_pid_speed_command_tb: FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/ptp_pkg.sv
src/ptp_in_if.sv
src/ptp_out_if.sv
src/ptp_cfg.sv
src/ptp_mul.sv
src/pan_tilt_pid_speed_command.sv
dv/pan_tilt_pid_speed_command_tb.sv
